### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the key/value table modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every rising edge while out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true while out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

### design/ikvt_pkg.sv
// ---------------------------------------------------------------------------
// ikvt_pkg
// Types and constants shared by the key/value table controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package ikvt_pkg;

    localparam int CMD_W  = 2;
    localparam int KEY_W  = 31;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    // Request opcodes.
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_EXIST = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADKEY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    // One table slot as held in the slot memory.
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } t_slot;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;   // write an empty slot at the sweep address
        logic load;    // capture a new request
        logic scan;    // step the slot search
        logic finish;  // update the table and register the result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last; // the sweep is at the last slot
        logic scan_done;  // a match was found or the last slot was checked
        logic key_neg;    // the offered request has a negative key
    } t_dp_stat;

endpackage

`default_nettype wire

### design/ikvt_dp.sv
// ---------------------------------------------------------------------------
// ikvt_dp
// Slot memory, address sweep, key compare and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ikvt_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ikvt_pkg::t_dp_cmd                     i_ctl,
    output ikvt_pkg::t_dp_stat                    o_stat,
    input  logic        [ikvt_pkg::CMD_W-1:0]     i_cmd,
    input  logic signed [ikvt_pkg::DATA_W-1:0]    i_key,
    input  logic signed [ikvt_pkg::DATA_W-1:0]    i_value,
    output logic signed [ikvt_pkg::DATA_W-1:0]    o_read_value,
    output logic                                  o_found,
    output logic        [ikvt_pkg::STAT_W-1:0]    o_status,
    output logic                                  o_done
);

    import ikvt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

    t_slot mem [TABLE_DEPTH];

    // Request registers.
    logic [CMD_W-1:0]  r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_val;
    logic              r_bad;

    // Search pipeline.
    logic [AW-1:0] r_addr;
    logic          r_issue_last;
    logic          r_chk_en;
    logic [AW-1:0] r_chk_idx;
    t_slot         r_rdata;

    // Search results.
    logic              r_hit;
    logic [AW-1:0]     r_hit_idx;
    logic [DATA_W-1:0] r_hit_val;
    logic              r_free_ok;
    logic [AW-1:0]     r_free_idx;

    // Result registers.
    logic [DATA_W-1:0] r_rd_out;
    logic              r_found;
    logic [STAT_W-1:0] r_status;
    logic              r_done;

    logic          issue;
    logic          check;
    logic          match;
    logic          we;
    logic [AW-1:0] waddr;
    t_slot         wdata;
    logic [STAT_W-1:0] n_status;
    logic [DATA_W-1:0] n_rd_out;

    assign issue = i_ctl.scan && !r_issue_last;
    assign check = i_ctl.scan && r_chk_en;
    assign match = r_rdata.valid && (r_rdata.key == r_key);

    assign o_stat.clear_last = (r_addr == LAST);
    assign o_stat.scan_done  = check && (match || (r_chk_idx == LAST));
    assign o_stat.key_neg    = i_key[DATA_W-1];

    // Table update and result of the finishing step.
    always_comb begin
        we       = 1'b0;
        waddr    = r_addr;
        wdata    = '0;
        n_status = ST_OK;
        n_rd_out = '0;
        if (i_ctl.clear) begin
            we = 1'b1;
        end else if (i_ctl.finish) begin
            if (r_bad) begin
                n_status = ST_BADKEY;
            end else if (r_cmd == CMD_SET) begin
                wdata = '{valid: 1'b1, key: r_key, value: r_val};
                if (r_hit) begin
                    we    = 1'b1;
                    waddr = r_hit_idx;
                end else if (r_free_ok) begin
                    we    = 1'b1;
                    waddr = r_free_idx;
                end else begin
                    n_status = ST_FULL;
                end
            end else if (r_cmd == CMD_GET) begin
                if (r_hit) begin
                    n_rd_out = r_hit_val;
                end
            end else if (r_cmd == CMD_DEL) begin
                if (r_hit) begin
                    we    = 1'b1;
                    waddr = r_hit_idx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (issue) begin
            r_rdata <= mem[r_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_issue_last <= 1'b0;
            r_chk_en     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_ok    <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_done <= i_ctl.finish;
            if (i_ctl.load) begin
                r_addr       <= '0;
                r_issue_last <= 1'b0;
                r_chk_en     <= 1'b0;
                r_hit        <= 1'b0;
                r_free_ok    <= 1'b0;
            end else begin
                if (i_ctl.clear || (issue && (r_addr != LAST))) begin
                    r_addr <= r_addr + AW'(1);
                end
                if (issue && (r_addr == LAST)) begin
                    r_issue_last <= 1'b1;
                end
                r_chk_en <= issue;
                if (check && match) begin
                    r_hit <= 1'b1;
                end
                if (check && !r_rdata.valid && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_key <= i_key[KEY_W-1:0];
            r_val <= i_value;
            r_bad <= i_key[DATA_W-1];
        end
        if (issue) begin
            r_chk_idx <= r_addr;
        end
        if (check && match) begin
            r_hit_idx <= r_chk_idx;
            r_hit_val <= r_rdata.value;
        end
        if (check && !r_rdata.valid && !r_free_ok) begin
            r_free_idx <= r_chk_idx;
        end
        if (i_ctl.finish) begin
            r_rd_out <= n_rd_out;
            r_found  <= r_hit;
            r_status <= n_status;
        end
    end

    assign o_read_value = r_rd_out;
    assign o_found      = r_found;
    assign o_status     = r_status;
    assign o_done       = r_done;

    `ASSERT_CLK(a_done_follows_finish, i_clk, i_rst_n, i_ctl.finish |=> r_done, "result strobe missing after finish")
    `ASSERT_CLK(a_full_only_on_set, i_clk, i_rst_n, (r_done && (r_status == ST_FULL)) |-> ((r_cmd == CMD_SET) && !r_found), "table full reported for a request other than a new set")
    `ASSERT_NEVER(a_no_write_bad_key, i_clk, i_rst_n, we && !i_ctl.clear && r_bad, "table written by a request with a negative key")

endmodule

`default_nettype wire

### design/ikvt_ctrl.sv
// ---------------------------------------------------------------------------
// ikvt_ctrl
// Sequencer for the clearing sweep, the slot search and the table update.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ikvt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    output ikvt_pkg::t_dp_cmd  o_ctl,
    input  ikvt_pkg::t_dp_stat i_stat
);

    import ikvt_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    n_state    = i_stat.key_neg ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_ctl.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    `ASSERT_CLK(a_accept_sets_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accepted request did not make the block busy")
    `ASSERT_CLK(a_busy_rise_on_start, i_clk, i_rst_n, $rose(busy) |-> $past(start), "busy rose without a request")
    `ASSERT_CLK(a_scan_holds, i_clk, i_rst_n, ((r_state == S_SCAN) && !i_stat.scan_done) |=> (r_state == S_SCAN), "search left before it was done")

endmodule

`default_nettype wire

### design/int_key_value_table_core.sv
// ---------------------------------------------------------------------------
// int_key_value_table_core
// Integer key to integer value table with set, get, delete and exist.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake        Signals
//   request   in         start / busy     i_cmd, i_key, i_value
//   result    out        o_done strobe    o_read_value, o_found, o_status
//
// A request transfer takes place at a rising edge with start high and busy
// low. Each request gives exactly one result, shown for one cycle with
// o_done high; the receiver cannot stall it.
// After reset the table is swept empty, one slot a cycle, with busy held
// high; no request is taken during the sweep.
// The slots are searched one per cycle through the single read port of the
// slot memory; the search of a request ends at the first matching slot or
// after the last slot. A request with a negative key skips the search.
// The result appears in the cycle after the table update, which is the
// first cycle in which busy is low again.
//
// The table keeps each slot as one word (valid flag, 31-bit key, value),
// so a delete only has to rewrite the word with the flag cleared. A set
// either rewrites the matching slot or fills the lowest free slot that the
// search passed on its way.
// ---------------------------------------------------------------------------
`default_nettype none

module int_key_value_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic        [ikvt_pkg::CMD_W-1:0]     i_cmd,
    input  logic signed [ikvt_pkg::DATA_W-1:0]    i_key,
    input  logic signed [ikvt_pkg::DATA_W-1:0]    i_value,
    output logic signed [ikvt_pkg::DATA_W-1:0]    o_read_value,
    output logic                                  o_found,
    output logic        [ikvt_pkg::STAT_W-1:0]    o_status,
    output logic                                  o_done
);

    import ikvt_pkg::*;

    // Commands and status between the sequencer and the datapath.
    t_dp_cmd  ctl;
    t_dp_stat stat;

    ikvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_ctl   (ctl),
        .i_stat  (stat)
    );

    // The datapath holds the slot memory and runs the search that the
    // sequencer steps; it also registers the result and its strobe.
    ikvt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_stat       (stat),
        .i_cmd        (i_cmd),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_read_value (o_read_value),
        .o_found      (o_found),
        .o_status     (o_status),
        .o_done       (o_done)
    );

endmodule

`default_nettype wire
